// File: design/smx_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; imported by every module of the block.
package smx_pkg;

   localparam int DATA_W = 16;

   localparam logic [7:0] OP_HALT   = 8'h00;
   localparam logic [7:0] OP_ADD    = 8'h10;
   localparam logic [7:0] OP_NEG    = 8'h11;
   localparam logic [7:0] OP_MUL    = 8'h12;
   localparam logic [7:0] OP_DIVMOD = 8'h13;
   localparam logic [7:0] OP_PUSH   = 8'h20;
   localparam logic [7:0] OP_POP    = 8'h21;
   localparam logic [7:0] OP_SWAP   = 8'h22;
   localparam logic [7:0] OP_READ   = 8'h30;
   localparam logic [7:0] OP_WRITE  = 8'h31;

   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_HALTED  = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   typedef struct packed {
      logic [7:0]               kind;
      logic signed [DATA_W-1:0] immediate;
      logic signed [DATA_W-1:0] read_value;
      logic                     clear;
   } req_word_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     out_valid;
      logic signed [DATA_W-1:0] out_value;
      logic [8:0]               depth_now;
   } rsp_word_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

endpackage

// File: design/smx_div.sv
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating.
// Depends on smx_pkg.
module smx_div (
   input  logic               clock,
   input  logic               reset,
   input  smx_pkg::div_req_type div_req,
   output smx_pkg::div_rsp_type div_rsp
);
   import smx_pkg::*;

   localparam int SW = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      trial    = {rem_ff, quo_ff[DATA_W-1]};
      diff     = trial - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         neg_q_in = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         neg_r_in = div_req.dividend[DATA_W-1];
         quo_in   = div_req.dividend[DATA_W-1] ? -div_req.dividend : div_req.dividend;
         den_in   = div_req.divisor[DATA_W-1] ? -div_req.divisor : div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
         end else begin
            rem_in = trial[DATA_W-1:0];
         end
         quo_in  = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = neg_q_ff ? -quo_ff : quo_ff;
   assign div_rsp.remainder = neg_r_ff ? -rem_ff : rem_ff;

endmodule

// File: design/stack_machine_executor_core.sv
// Top level of the 16-bit stack machine executor: sequencer, operand stack memory, ALU.
// Depends on smx_pkg and smx_div.
//
//   channel  ports                      handshake
//   request  start, busy, req_data      taken at clock edge with start high, busy low
//   result   rsp_strobe, rsp_data       one word per request, shown for one cycle
//
// Halt, clear, unknown opcodes and items while stopped: strobe in the cycle after start.
// Push/read: S_PUSH, S_DONE. Others: S_POP and S_POPW per operand (an empty pop skips
// S_POPW, the registered stack memory read), S_EXEC, S_PUSH per result, S_DONE.
// Pop/write push nothing; divmod waits in S_DIVW on the one-bit-per-cycle divider.
// Reset empties the stack and sets status normal; memory contents are not cleared.
// The receiver cannot stall; busy is low again in the cycle the strobe shows.
module stack_machine_executor_core #(
   parameter int unsigned STACK_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  smx_pkg::req_word_type req_data,
   output logic                  rsp_strobe,
   output smx_pkg::rsp_word_type rsp_data
);
   import smx_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_POP  = 7'b0000010,
      S_POPW = 7'b0000100,
      S_EXEC = 7'b0001000,
      S_DIVW = 7'b0010000,
      S_PUSH = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        op_ff, op_in;
   logic [1:0]        pops_ff, pops_in;
   logic              pop_idx_ff, pop_idx_in;
   logic [1:0]        npush_ff, npush_in;
   logic [DATA_W-1:0] p1_ff, p1_in;
   logic [DATA_W-1:0] p2_ff, p2_in;
   logic [DATA_W-1:0] r1_ff, r1_in;
   logic [DATA_W-1:0] r2_ff, r2_in;
   logic              wv_ff, wv_in;
   logic [DATA_W-1:0] wval_ff, wval_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;

   logic [2*DATA_W-1:0] prod;
   logic                emit;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   smx_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign prod = p2_ff * p1_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pops_in       = pops_ff;
      pop_idx_in    = pop_idx_ff;
      npush_in      = npush_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      wv_in         = wv_ff;
      wval_in       = wval_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_raddr     = AW'(count_ff - 1'b1);
      mem_waddr     = AW'(count_ff);
      div_req.start    = 1'b0;
      div_req.dividend = p2_ff;
      div_req.divisor  = p1_ff;
      emit          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_data.kind;
               wv_in      = 1'b0;
               wval_in    = '0;
               pop_idx_in = 1'b0;
               if (req_data.clear) begin
                  count_in  = '0;
                  status_in = ST_NORMAL;
                  emit      = 1'b1;
               end else if (status_ff != ST_NORMAL) begin
                  emit = 1'b1;
               end else begin
                  case (req_data.kind)
                     OP_HALT: begin
                        status_in = ST_HALTED;
                        emit      = 1'b1;
                     end
                     OP_PUSH: begin
                        r1_in    = req_data.immediate;
                        npush_in = 2'd1;
                        state_in = S_PUSH;
                     end
                     OP_READ: begin
                        r1_in    = req_data.read_value;
                        npush_in = 2'd1;
                        state_in = S_PUSH;
                     end
                     OP_POP, OP_WRITE, OP_NEG: begin
                        pops_in  = 2'd1;
                        state_in = S_POP;
                     end
                     OP_ADD, OP_MUL, OP_DIVMOD, OP_SWAP: begin
                        pops_in  = 2'd2;
                        state_in = S_POP;
                     end
                     default: begin
                        status_in = ST_ILLEGAL;
                        emit      = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_POP: begin
            if (count_ff == '0) begin
               status_in = ST_ILLEGAL;
               if (pop_idx_ff) begin
                  p2_in = '0;
               end else begin
                  p1_in = '0;
               end
               pops_in    = pops_ff - 1'b1;
               pop_idx_in = 1'b1;
               state_in   = (pops_ff == 2'd1) ? S_EXEC : S_POP;
            end else begin
               mem_re   = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            if (pop_idx_ff) begin
               p2_in = rd_data_ff;
            end else begin
               p1_in = rd_data_ff;
            end
            pops_in    = pops_ff - 1'b1;
            pop_idx_in = 1'b1;
            state_in   = (pops_ff == 2'd1) ? S_EXEC : S_POP;
         end
         S_EXEC: begin
            state_in = S_PUSH;
            npush_in = 2'd1;
            case (op_ff)
               OP_ADD: r1_in = p2_ff + p1_ff;
               OP_NEG: r1_in = -p1_ff;
               OP_MUL: r1_in = prod[DATA_W-1:0];
               OP_DIVMOD: begin
                  if (p1_ff == '0) begin
                     status_in = ST_ILLEGAL;
                     r1_in     = '0;
                     r2_in     = '0;
                     npush_in  = 2'd2;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIVW;
                  end
               end
               OP_SWAP: begin
                  r1_in    = p1_ff;
                  r2_in    = p2_ff;
                  npush_in = 2'd2;
               end
               OP_WRITE: begin
                  wv_in    = 1'b1;
                  wval_in  = p1_ff;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               r1_in    = div_rsp.quotient;
               r2_in    = div_rsp.remainder;
               npush_in = 2'd2;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (count_ff >= CW'(STACK_DEPTH)) begin
               status_in = ST_ILLEGAL;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            r1_in    = r2_ff;
            npush_in = npush_ff - 1'b1;
            if (npush_ff == 2'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         rsp_strobe_in         = 1'b1;
         rsp_data_in.status    = status_in;
         rsp_data_in.out_valid = wv_in;
         rsp_data_in.out_value = wval_in;
         rsp_data_in.depth_now = 9'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         status_ff     <= ST_NORMAL;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff       <= op_in;
      pops_ff     <= pops_in;
      pop_idx_ff  <= pop_idx_in;
      npush_ff    <= npush_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      wv_ff       <= wv_in;
      wval_ff     <= wval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= r1_ff;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: design/smx_checker.sv
// Port-level checks for stack_machine_executor_core, bound to the top level.
// Depends on smx_pkg.
module smx_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input smx_pkg::req_word_type req_data,
   input logic                  rsp_strobe,
   input smx_pkg::rsp_word_type rsp_data
);
   import smx_pkg::*;

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result word right after reset");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.clear) |=>
         (rsp_strobe && rsp_data.status == ST_NORMAL && rsp_data.depth_now == 9'd0 &&
          !rsp_data.out_valid))
      else $error("clear did not answer normal and empty");

   a_done_strobes: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy fell without a result word");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.out_valid) |-> (rsp_data.out_value == '0))
      else $error("out_value nonzero without out_valid");

   a_stopped_holds_depth: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.clear && $past(rsp_strobe) &&
       !$past(start && !busy) && $past(rsp_data.status) != ST_NORMAL) |=>
         (rsp_strobe && rsp_data.depth_now == $past(rsp_data.depth_now, 2)))
      else $error("item while stopped changed depth");

endmodule

bind stack_machine_executor_core smx_checker u_smx_checker (.*);

// File: dv/smx_checker.sv
`timescale 1ns / 1ps
// Checker for the stack machine executor: watches request and result words, keeps its own
// operand stack model and compares every result word field by field. Depends on smx_pkg.
module smx_tb_checker
   import smx_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_data,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_data,
   output int           error_count,
   output int           results_due
);

   logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
   int unsigned              stack_fill;
   logic [1:0]               run_state;
   rsp_word_type             predicted_words [$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      error_count++;
   endtask

   function automatic int pop_operand();
      if (stack_fill == 0) begin
         run_state = ST_ILLEGAL;
         return 0;
      end
      stack_fill--;
      return stack_mem[stack_fill];
   endfunction

   function automatic void push_operand(input int v);
      if (stack_fill >= STACK_DEPTH) begin
         run_state = ST_ILLEGAL;
         return;
      end
      stack_mem[stack_fill] = v[DATA_W-1:0];
      stack_fill++;
   endfunction

   task automatic execute_instruction(input req_word_type w, output rsp_word_type r);
      int a;
      int b;
      r = '0;
      if (w.clear) begin
         stack_fill = 0;
         run_state  = ST_NORMAL;
      end else if (run_state == ST_NORMAL) begin
         case (w.kind)
            OP_HALT: run_state = ST_HALTED;
            OP_ADD: begin
               b = pop_operand();
               a = pop_operand();
               push_operand(a + b);
            end
            OP_NEG: begin
               a = pop_operand();
               push_operand(-a);
            end
            OP_MUL: begin
               b = pop_operand();
               a = pop_operand();
               push_operand(a * b);
            end
            OP_DIVMOD: begin
               b = pop_operand();
               a = pop_operand();
               if (b == 0) begin
                  run_state = ST_ILLEGAL;
                  push_operand(0);
                  push_operand(0);
               end else begin
                  push_operand(a / b);
                  push_operand(a % b);
               end
            end
            OP_PUSH: push_operand(int'(w.immediate));
            OP_POP:  a = pop_operand();
            OP_SWAP: begin
               a = pop_operand();
               b = pop_operand();
               push_operand(a);
               push_operand(b);
            end
            OP_READ: push_operand(int'(w.read_value));
            OP_WRITE: begin
               a           = pop_operand();
               r.out_valid = 1'b1;
               r.out_value = a[DATA_W-1:0];
            end
            default: run_state = ST_ILLEGAL;
         endcase
      end
      r.status    = run_state;
      r.depth_now = stack_fill[8:0];
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         stack_fill = 0;
         run_state  = ST_NORMAL;
         predicted_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (predicted_words.size() == 0) begin
               report_mismatch($sformatf("result word with none predicted: %h", rsp_data));
            end else begin
               want = predicted_words.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.out_valid !== want.out_valid)
                  report_mismatch($sformatf("out_valid got %0b want %0b",
                                            rsp_data.out_valid, want.out_valid));
               if (rsp_data.out_value !== want.out_value)
                  report_mismatch($sformatf("out_value got %0d want %0d",
                                            rsp_data.out_value, want.out_value));
               if (rsp_data.depth_now !== want.depth_now)
                  report_mismatch($sformatf("depth_now got %0d want %0d",
                                            rsp_data.depth_now, want.depth_now));
            end
         end
         if (start && !busy) begin
            execute_instruction(req_data, want);
            predicted_words = {predicted_words, want};
         end
      end
      results_due = predicted_words.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the stack machine executor testbench: clock, reset, instruction stimulus and verdict.
// Depends on smx_pkg, stack_machine_executor_core and smx_tb_checker.
module tb_top;
   import smx_pkg::*;

   localparam int unsigned STACK_DEPTH = 256;
   localparam int          ITEM_TARGET = 850;
   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [7:0]  OP_UNKNOWN  = 8'hFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_data = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_data;
   int           error_count;
   int           results_due;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           sent_count = 0;
   bit           first_fill_done = 0;
   bit           second_fill_done = 0;

   always #5 clock = ~clock;

   stack_machine_executor_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   smx_tb_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0001;
         4:       return 16'hFFFF;
         5:       return 16'($urandom_range(0, 20)) - 16'd10;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_word_type make_word(input logic [7:0] kind, input logic clear);
      req_word_type w;
      w.kind       = kind;
      w.immediate  = pick_value();
      w.read_value = pick_value();
      w.clear      = clear;
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_op(input logic [7:0] kind, input logic [DATA_W-1:0] value);
      req_word_type w;
      w            = make_word(kind, 1'b0);
      w.immediate  = value;
      w.read_value = value;
      send_word(w);
   endtask

   task automatic drain();
      start <= 1'b0;
      wait (results_due == 0);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_legal_op(input int depth);
      logic [7:0] op;
      bit         ok;
      do begin
         case ($urandom_range(0, 8))
            0:       op = OP_PUSH;
            1:       op = OP_READ;
            2:       op = OP_ADD;
            3:       op = OP_NEG;
            4:       op = OP_MUL;
            5:       op = OP_DIVMOD;
            6:       op = OP_POP;
            7:       op = OP_SWAP;
            default: op = OP_WRITE;
         endcase
         case (op)
            OP_PUSH, OP_READ:                  ok = depth < STACK_DEPTH;
            OP_ADD, OP_MUL, OP_DIVMOD, OP_SWAP: ok = depth >= 2;
            default:                           ok = depth >= 1;
         endcase
      end while (!ok);
      return op;
   endfunction

   task automatic run_program(input int depth, input int len);
      logic [7:0] op;
      repeat (len) begin
         if ($urandom_range(0, 39) == 0) begin
            send_word(make_word(8'($urandom), 1'b1));
            depth = 0;
         end else begin
            op = pick_legal_op(depth);
            send_word(make_word(op, 1'b0));
            case (op)
               OP_PUSH, OP_READ:                depth++;
               OP_ADD, OP_MUL, OP_POP, OP_WRITE: depth--;
               default:                         ;
            endcase
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         send_word(make_word(OP_HALT, 1'b0));
         repeat ($urandom_range(1, 2)) send_word(make_word(8'($urandom), 1'b0));
      end
   endtask

   task automatic fill_stack(input int pushes);
      send_word(make_word(8'($urandom), 1'b1));
      repeat (pushes) send_word(make_word($urandom_range(0, 1) ? OP_PUSH : OP_READ, 1'b0));
      run_program(pushes, $urandom_range(5, 15));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, wrap cases and the error paths
      send_word(make_word(OP_WRITE, 1'b1));
      send_op(OP_PUSH, 16'h7FFF);
      send_op(OP_PUSH, 16'h8000);
      send_op(OP_ADD, 16'h0000);
      send_op(OP_PUSH, 16'h8000);
      send_op(OP_PUSH, 16'hFFFF);
      send_op(OP_DIVMOD, 16'h0000);
      send_op(OP_WRITE, 16'h0000);
      send_op(OP_WRITE, 16'h0000);
      send_op(OP_READ, 16'hFFF9);
      send_op(OP_PUSH, 16'h0002);
      send_op(OP_DIVMOD, 16'h0000);
      send_op(OP_SWAP, 16'h0000);
      send_op(OP_MUL, 16'h0000);
      send_op(OP_NEG, 16'h0000);
      send_op(OP_WRITE, 16'h0000);
      send_op(OP_POP, 16'h0000);
      send_op(OP_POP, 16'h0000);
      send_op(OP_PUSH, 16'h0005);
      send_word(make_word(OP_PUSH, 1'b1));
      send_op(OP_DIVMOD, 16'h0000);
      send_word(make_word(OP_READ, 1'b1));
      send_op(OP_WRITE, 16'h0000);
      send_word(make_word(OP_NEG, 1'b1));
      send_op(OP_UNKNOWN, 16'hFFFF);
      send_word(make_word(OP_HALT, 1'b1));
      send_op(OP_HALT, 16'h0000);
      send_op(OP_READ, 16'h1234);
      drain();

      while (sent_count < ITEM_TARGET) begin
         if (!first_fill_done && sent_count > 300) begin
            first_fill_done = 1;
            fill_stack(STACK_DEPTH);
         end else if (!second_fill_done && sent_count > 600) begin
            second_fill_done = 1;
            fill_stack(STACK_DEPTH + $urandom_range(1, 3));
         end else begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  repeat ($urandom_range(1, 8))
                     send_word(make_word(8'($urandom), $urandom_range(0, 7) == 0));
               end
               2: begin
                  send_word(make_word(8'($urandom), 1'b1));
                  repeat ($urandom_range(5, 15))
                     send_word(make_word(pick_legal_op(STACK_DEPTH), 1'b0));
               end
               default: begin
                  send_word(make_word(8'($urandom), 1'b1));
                  run_program(0, $urandom_range(3, 30));
               end
            endcase
         end
         if ($urandom_range(0, 14) == 0) drain();
      end

      drain();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/smx_pkg.sv
design/smx_div.sv
design/stack_machine_executor_core.sv
design/smx_checker.sv
dv/smx_checker.sv
dv/tb_top.sv
